// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the sector cache controller.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int SECTOR_ADDR_W = 48;
  localparam int REQ_END_W     = 49;
  localparam int BUF_OFF_W     = 16;
  localparam int RAM_SECTOR_W  = 23;
  localparam int RUN_W         = 7;
  localparam int ROOM_W        = 8;
  localparam int COUNT_W       = 48;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 23;

  // Longest fetch run, destination window and sector size
  localparam logic [RUN_W-1:0] FETCH_CAP     = 7'd64;
  localparam int               BOUND_W       = 17;
  localparam logic [BOUND_W-1:0] BOUNDARY_BYTES = 17'h10000;
  localparam int               SECTOR_SHIFT  = 9;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_FILL      = 2'd1,
    OP_WRITE_OK  = 2'd2,
    OP_WRITE_ERR = 2'd3
  } scc_op_t;

  typedef enum logic [2:0] {
    ACT_RAM_READ  = 3'd0,
    ACT_NEW_RUN   = 3'd1,
    ACT_EXTEND    = 3'd2,
    ACT_WR_STORED = 3'd3,
    ACT_WR_SKIP   = 3'd4,
    ACT_INVAL     = 3'd5,
    ACT_NO_CHANGE = 3'd6,
    ACT_FILLED    = 3'd7
  } scc_act_t;

  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_WINDOW = 2'd1;
  localparam logic [1:0] MODE_CACHE  = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_WINDOW  = 2'd1,
    CFG_MAX_RUN = 2'd2,
    CFG_NONE    = 2'd3
  } scc_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2
  } scc_state_t;

  typedef struct packed {
    logic clear_en;
    logic capture;
    logic commit;
  } scc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } scc_sts_t;

endpackage

// ===== rtl/scc_chan_if.sv =====
// ----------------------------------------------------------------------------
// scc_chan_if
// Request and response channels of the sector cache controller.
// ----------------------------------------------------------------------------
interface scc_req_if
  import scc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [SECTOR_ADDR_W-1:0] sector_addr;
  logic [REQ_END_W-1:0]     request_end;
  logic                     first_of_request;
  logic [BUF_OFF_W-1:0]     buffer_offset;

  modport source (
    output valid, opcode, sector_addr, request_end, first_of_request, buffer_offset,
    input  ready
  );
  modport sink (
    input  valid, opcode, sector_addr, request_end, first_of_request, buffer_offset,
    output ready
  );
endinterface

interface scc_rsp_if
  import scc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [2:0]              action;
  logic [RAM_SECTOR_W-1:0] ram_sector;
  logic [RUN_W-1:0]        run_length;
  logic [COUNT_W-1:0]      hit_total;
  logic [COUNT_W-1:0]      fetch_total;

  modport source (
    output valid, action, ram_sector, run_length, hit_total, fetch_total,
    input  ready
  );
  modport sink (
    input  valid, action, ram_sector, run_length, hit_total, fetch_total,
    output ready
  );
endinterface

// ===== rtl/scc_ram.sv =====
// ----------------------------------------------------------------------------
// scc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: tag clearing sweep after reset, then capture and commit per word.
// ----------------------------------------------------------------------------
module scc_ctrl
  import scc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  scc_sts_t sts,
  output scc_cmd_t cmd
);

  scc_state_t state;
  scc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.clear_en = 1'b0;
    cmd.capture  = 1'b0;
    cmd.commit   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold the looked-up word until the result register frees up
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/scc_dp.sv =====
// ----------------------------------------------------------------------------
// scc_dp
// Datapath: configuration, tag store, run tracking, counters, result register.
// ----------------------------------------------------------------------------
module scc_dp
  import scc_pkg::*;
#(
  parameter int SLOTS     = 4096,
  parameter int ADDR_BITS = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  scc_cmd_t                 cmd,
  output scc_sts_t                 sts,
  input  logic                     cfg_we,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic [1:0]               opcode,
  input  logic [SECTOR_ADDR_W-1:0] sector_addr,
  input  logic [REQ_END_W-1:0]     request_end,
  input  logic                     first_of_request,
  input  logic [BUF_OFF_W-1:0]     buffer_offset,
  scc_rsp_if.source                rsp
);

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int AW        = (ADDR_BITS < SECTOR_ADDR_W) ? ADDR_BITS : SECTOR_ADDR_W;
  localparam int TAG_W     = AW - SLOT_BITS;
  localparam int ENTRY_W   = TAG_W + 1;

  // configuration
  logic [1:0]              mode;
  logic [RAM_SECTOR_W-1:0] window;
  logic [RUN_W-1:0]        max_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PASS;
      window  <= '0;
      max_run <= FETCH_CAP;
    end else if (cfg_we) begin
      case (scc_cfg_idx_t'(cfg_index))
        CFG_MODE:    mode    <= cfg_data[1:0];
        CFG_WINDOW:  window  <= cfg_data[RAM_SECTOR_W-1:0];
        CFG_MAX_RUN: max_run <= cfg_data[RUN_W-1:0];
        default:     ;
      endcase
    end
  end

  // captured word and its precomputed compares
  logic [SECTOR_ADDR_W-1:0] addr_in;
  logic [BOUND_W-1:0]       room_diff;
  logic [ROOM_W-1:0]        room_in;

  scc_op_t                  op_q;
  logic [SECTOR_ADDR_W-1:0] addr_q;
  logic                     first_q;
  logic [ROOM_W-1:0]        room_q;
  logic                     win_read_q;
  logic                     win_write_q;

  assign addr_in   = SECTOR_ADDR_W'(sector_addr[AW-1:0]);
  assign room_diff = BOUNDARY_BYTES - {1'b0, buffer_offset};
  assign room_in   = (room_diff[BOUND_W-1:SECTOR_SHIFT] == '0) ? ROOM_W'(1)
                                                                : room_diff[BOUND_W-1:SECTOR_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q        <= scc_op_t'(opcode);
      addr_q      <= addr_in;
      first_q     <= first_of_request;
      room_q      <= room_in;
      win_read_q  <= (mode == MODE_WINDOW) && (request_end <= REQ_END_W'(window)) &&
                     (REQ_END_W'(addr_in) < request_end);
      win_write_q <= (mode == MODE_WINDOW) && (addr_in < SECTOR_ADDR_W'(window));
    end
  end

  // tag store, cleared by a sweep after reset
  logic [SLOT_BITS-1:0] clr_addr;
  logic [SLOT_BITS-1:0] slot_in;
  logic [SLOT_BITS-1:0] slot_q;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 tag_we;
  logic [ENTRY_W-1:0]   tag_wdata;
  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [SLOT_BITS-1:0] ram_raddr;
  logic                 tag_hit;

  assign slot_in = addr_in[SLOT_BITS-1:0];
  assign slot_q  = addr_q[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + SLOT_BITS'(1);
    end
  end

  assign sts.clear_last = (clr_addr == SLOT_BITS'(SLOTS - 1));

  assign ram_we    = cmd.clear_en | (cmd.commit & tag_we);
  assign ram_waddr = cmd.clear_en ? clr_addr : slot_q;
  assign ram_wdata = cmd.clear_en ? '0 : tag_wdata;
  assign ram_raddr = cmd.capture ? slot_in : slot_q;

  scc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_tags (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (rd_data)
  );

  assign tag_hit = rd_data[TAG_W] && (rd_data[TAG_W-1:0] == addr_q[AW-1:SLOT_BITS]);

  // run state and counters
  logic [RUN_W-1:0]   run_count;
  logic [ROOM_W-1:0]  run_room;
  logic [COUNT_W-1:0] hit_counter;
  logic [COUNT_W-1:0] fetch_counter;
  logic [RUN_W-1:0]   run_count_next;
  logic [ROOM_W-1:0]  run_room_next;
  logic [COUNT_W-1:0] hit_counter_next;
  logic [COUNT_W-1:0] fetch_counter_next;
  logic [RUN_W-1:0]   cap_run;
  logic [ROOM_W-1:0]  cap;
  logic               extend;

  scc_act_t                act;
  logic [RAM_SECTOR_W-1:0] ram_sec;
  logic [RUN_W-1:0]        run_len;

  always_comb begin
    if (max_run == '0) begin
      cap_run = RUN_W'(1);
    end else if (max_run > FETCH_CAP) begin
      cap_run = FETCH_CAP;
    end else begin
      cap_run = max_run;
    end
    cap    = (run_room < {1'b0, cap_run}) ? run_room : {1'b0, cap_run};
    extend = !first_q && (run_count != '0) && ({1'b0, run_count} < cap);
  end

  always_comb begin
    act                = ACT_NO_CHANGE;
    ram_sec            = '0;
    run_len            = '0;
    run_count_next     = run_count;
    run_room_next      = run_room;
    hit_counter_next   = hit_counter;
    fetch_counter_next = fetch_counter;
    tag_we             = 1'b0;
    tag_wdata          = {1'b1, addr_q[AW-1:SLOT_BITS]};
    case (op_q)
      OP_READ: begin
        if (win_read_q || (mode == MODE_CACHE && tag_hit)) begin
          act              = ACT_RAM_READ;
          ram_sec          = win_read_q ? addr_q[RAM_SECTOR_W-1:0]
                                        : RAM_SECTOR_W'(slot_q);
          run_count_next   = '0;
          hit_counter_next = hit_counter + COUNT_W'(1);
        end else begin
          if (extend) begin
            act            = ACT_EXTEND;
            run_count_next = run_count + RUN_W'(1);
          end else begin
            act            = ACT_NEW_RUN;
            run_room_next  = room_q;
            run_count_next = RUN_W'(1);
          end
          run_len            = run_count_next;
          fetch_counter_next = fetch_counter + COUNT_W'(1);
        end
      end
      OP_FILL: begin
        if (mode == MODE_CACHE) begin
          act     = ACT_FILLED;
          ram_sec = RAM_SECTOR_W'(slot_q);
          tag_we  = 1'b1;
        end
      end
      OP_WRITE_OK: begin
        if (win_write_q) begin
          act     = ACT_WR_STORED;
          ram_sec = addr_q[RAM_SECTOR_W-1:0];
        end else if (mode == MODE_CACHE) begin
          act     = ACT_WR_STORED;
          ram_sec = RAM_SECTOR_W'(slot_q);
          tag_we  = 1'b1;
        end else begin
          act = ACT_WR_SKIP;
        end
      end
      OP_WRITE_ERR: begin
        if (mode == MODE_CACHE && tag_hit) begin
          act       = ACT_INVAL;
          ram_sec   = RAM_SECTOR_W'(slot_q);
          tag_we    = 1'b1;
          tag_wdata = {1'b0, addr_q[AW-1:SLOT_BITS]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count     <= '0;
      run_room      <= '0;
      hit_counter   <= '0;
      fetch_counter <= '0;
    end else if (cmd.commit) begin
      run_count     <= run_count_next;
      run_room      <= run_room_next;
      hit_counter   <= hit_counter_next;
      fetch_counter <= fetch_counter_next;
    end
  end

  // result register
  logic                    out_valid;
  logic [2:0]              out_action;
  logic [RAM_SECTOR_W-1:0] out_ram_sector;
  logic [RUN_W-1:0]        out_run_length;
  logic [COUNT_W-1:0]      out_hit;
  logic [COUNT_W-1:0]      out_fetch;

  assign sts.out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_action     <= act;
      out_ram_sector <= ram_sec;
      out_run_length <= run_len;
      out_hit        <= hit_counter_next;
      out_fetch      <= fetch_counter_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.action      = out_action;
  assign rsp.ram_sector  = out_ram_sector;
  assign rsp.run_length  = out_run_length;
  assign rsp.hit_total   = out_hit;
  assign rsp.fetch_total = out_fetch;

endmodule

// ===== rtl/sector_cache_controller_core.sv =====
// ----------------------------------------------------------------------------
// sector_cache_controller_core
// Per-sector lookup for a block-device RAM cache: window, tag store, fetch runs.
// ----------------------------------------------------------------------------
//   port      dir  kind           carries
//   req       in   valid/ready    opcode, sector_addr, request_end,
//                                 first_of_request, buffer_offset
//   rsp       out  valid/ready    action, ram_sector, run_length,
//                                 hit_total, fetch_total
//   cfg_*     in   write enable   mode, ram_window_sectors, max_run
//
// Each word is captured with the tag read, then committed with the tag write,
// in a single read/write pass through the tag RAM.
// After reset a sweep clears the tag RAM, with req.ready low.
// The result register lets a new word be captured while the last result waits;
// the commit then holds until rsp.ready frees that register.
// ----------------------------------------------------------------------------
module sector_cache_controller_core
  import scc_pkg::*;
#(
  parameter int SLOTS     = 4096,
  parameter int ADDR_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  scc_req_if.sink                req,
  scc_rsp_if.source              rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  scc_cmd_t cmd;
  scc_sts_t sts;
  logic     in_ready;

  assign req.ready = in_ready;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scc_dp #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .opcode           (req.opcode),
    .sector_addr      (req.sector_addr),
    .request_end      (req.request_end),
    .first_of_request (req.first_of_request),
    .buffer_offset    (req.buffer_offset),
    .rsp              (rsp)
  );

endmodule

// ===== tb/sector_cache_controller_core_test.sv =====
// ----------------------------------------------------------------------------
// sector_cache_controller_core_test
// Self-checking bench for the sector cache controller. A cycle-free model
// predicts every result word from the accepted request words: window reads,
// tag hits, fetch-run merging, fills, writes and invalidation, plus the hit
// and fetch totals. Stimulus is a short directed opener and then random
// read requests, fills and writes over several mode, window and run-cap
// settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module sector_cache_controller_core_test;
  import scc_pkg::*;

  localparam int SLOT_COUNT = 4096;
  // covers the tag clear sweep after reset plus the longest stalls
  localparam int IDLE_LIMIT = 20000;
  localparam logic [SECTOR_ADDR_W:0] ADDR_SPAN = 49'h1_0000_0000_0000;

  typedef struct {
    scc_op_t                  opcode;
    logic [SECTOR_ADDR_W-1:0] sector_addr;
    logic [REQ_END_W-1:0]     request_end;
    logic                     first_of_request;
    logic [BUF_OFF_W-1:0]     buffer_offset;
  } sector_word_t;

  typedef struct {
    scc_act_t                action;
    logic [RAM_SECTOR_W-1:0] ram_sector;
    logic [RUN_W-1:0]        run_length;
    logic [COUNT_W-1:0]      hit_total;
    logic [COUNT_W-1:0]      fetch_total;
  } lookup_result_t;

  class sector_lookup_model;
    logic [SECTOR_ADDR_W-1:0] tag_addr [SLOT_COUNT];
    bit                       tag_live [SLOT_COUNT];
    logic [1:0]               mode;
    logic [RAM_SECTOR_W-1:0]  window;
    logic [RUN_W-1:0]         max_run;
    logic [RUN_W-1:0]         run_count;
    logic [ROOM_W-1:0]        run_room;
    logic [COUNT_W-1:0]       hit_count;
    logic [COUNT_W-1:0]       fetch_count;
    lookup_result_t           pending_results[$];
    int                       mismatches;

    function new();
      foreach (tag_live[i]) tag_live[i] = 1'b0;
      mode        = MODE_PASS;
      window      = '0;
      max_run     = FETCH_CAP;
      run_count   = '0;
      run_room    = '0;
      hit_count   = '0;
      fetch_count = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(scc_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE:    mode = data[1:0];
        CFG_WINDOW:  window = data[RAM_SECTOR_W-1:0];
        CFG_MAX_RUN: max_run = data[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function void accept_word(sector_word_t w);
      int unsigned    slot;
      int unsigned    limit;
      int             room;
      bit             tag_hit;
      bit             in_window;
      lookup_result_t r;
      slot = w.sector_addr % SLOT_COUNT;
      tag_hit = tag_live[slot] && (tag_addr[slot] == w.sector_addr);
      r.action = ACT_NO_CHANGE;
      r.ram_sector = '0;
      r.run_length = '0;
      case (w.opcode)
        OP_READ: begin
          in_window = (mode == MODE_WINDOW) && (w.request_end <= window) &&
                      (w.sector_addr < w.request_end);
          if (in_window || (mode == MODE_CACHE && tag_hit)) begin
            r.action = ACT_RAM_READ;
            r.ram_sector = in_window ? w.sector_addr[RAM_SECTOR_W-1:0]
                                     : RAM_SECTOR_W'(slot);
            run_count = '0;
            hit_count = hit_count + 1'b1;
          end else begin
            // clamp the cap, then bound it by room left before the 64 KB edge
            limit = (max_run == 0) ? 1 : ((max_run > FETCH_CAP) ? FETCH_CAP : max_run);
            if (run_room < limit) limit = run_room;
            if (!w.first_of_request && run_count != 0 && run_count < limit) begin
              run_count = run_count + 1'b1;
              r.action = ACT_EXTEND;
            end else begin
              room = (int'(BOUNDARY_BYTES) - int'(w.buffer_offset)) >> SECTOR_SHIFT;
              run_room = (room == 0) ? ROOM_W'(1) : ROOM_W'(room);
              run_count = RUN_W'(1);
              r.action = ACT_NEW_RUN;
            end
            r.run_length = run_count;
            fetch_count = fetch_count + 1'b1;
          end
        end
        OP_FILL: begin
          if (mode == MODE_CACHE) begin
            tag_addr[slot] = w.sector_addr;
            tag_live[slot] = 1'b1;
            r.action = ACT_FILLED;
            r.ram_sector = RAM_SECTOR_W'(slot);
          end
        end
        OP_WRITE_OK: begin
          if (mode == MODE_WINDOW && w.sector_addr < window) begin
            r.action = ACT_WR_STORED;
            r.ram_sector = w.sector_addr[RAM_SECTOR_W-1:0];
          end else if (mode == MODE_CACHE) begin
            tag_addr[slot] = w.sector_addr;
            tag_live[slot] = 1'b1;
            r.action = ACT_WR_STORED;
            r.ram_sector = RAM_SECTOR_W'(slot);
          end else begin
            r.action = ACT_WR_SKIP;
          end
        end
        OP_WRITE_ERR: begin
          if (mode == MODE_CACHE && tag_hit) begin
            tag_live[slot] = 1'b0;
            r.action = ACT_INVAL;
            r.ram_sector = RAM_SECTOR_W'(slot);
          end
        end
        default: ;
      endcase
      r.hit_total = hit_count;
      r.fetch_total = fetch_count;
      pending_results.push_back(r);
    endfunction

    function void compare_result(lookup_result_t got);
      lookup_result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with none outstanding: action %0d", got.action);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.action !== want.action) begin
        $error("action: expected %0d, actual %0d", want.action, got.action);
        mismatches++;
      end
      if (got.ram_sector !== want.ram_sector) begin
        $error("ram_sector: expected %0d, actual %0d", want.ram_sector, got.ram_sector);
        mismatches++;
      end
      if (got.run_length !== want.run_length) begin
        $error("run_length: expected %0d, actual %0d", want.run_length, got.run_length);
        mismatches++;
      end
      if (got.hit_total !== want.hit_total) begin
        $error("hit_total: expected %0d, actual %0d", want.hit_total, got.hit_total);
        mismatches++;
      end
      if (got.fetch_total !== want.fetch_total) begin
        $error("fetch_total: expected %0d, actual %0d", want.fetch_total, got.fetch_total);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  scc_req_if req_ch ();
  scc_rsp_if rsp_ch ();

  sector_cache_controller_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sector_lookup_model       cache_model = new();
  bit                       src_gaps;
  bit                       sink_stalls;
  int unsigned              items_sent;
  int                       idle_cycles;
  int                       stall_left;
  logic [SECTOR_ADDR_W-1:0] recent_starts[$];

  always #4 clk = ~clk;

  // response ready: random stall bursts while enabled
  always @(negedge clk) begin
    if (stall_left == 0 && sink_stalls && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 5);
    if (stall_left > 0) begin
      rsp_ch.ready = 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    lookup_result_t got;
    sector_word_t   w;
    if (!rst) begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.action      = scc_act_t'(rsp_ch.action);
        got.ram_sector  = rsp_ch.ram_sector;
        got.run_length  = rsp_ch.run_length;
        got.hit_total   = rsp_ch.hit_total;
        got.fetch_total = rsp_ch.fetch_total;
        cache_model.compare_result(got);
      end
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
        w.opcode           = scc_op_t'(req_ch.opcode);
        w.sector_addr      = req_ch.sector_addr;
        w.request_end      = req_ch.request_end;
        w.first_of_request = req_ch.first_of_request;
        w.buffer_offset    = req_ch.buffer_offset;
        cache_model.accept_word(w);
      end
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  function automatic sector_word_t make_word(scc_op_t op, logic [SECTOR_ADDR_W-1:0] addr,
                                             logic [REQ_END_W-1:0] rend, logic first,
                                             logic [BUF_OFF_W-1:0] boff);
    sector_word_t w;
    w.opcode           = op;
    w.sector_addr      = addr;
    w.request_end      = rend;
    w.first_of_request = first;
    w.buffer_offset    = boff;
    return w;
  endfunction

  function automatic logic [REQ_END_W-1:0] random_end();
    int unsigned dice;
    dice = $urandom_range(0, 19);
    if (dice < 2) return ADDR_SPAN;
    if (dice < 11) return {1'b0, 16'($urandom), 32'($urandom)};
    return REQ_END_W'($urandom_range(0, 9000));
  endfunction

  function automatic logic [BUF_OFF_W-1:0] pick_offset();
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (dice < 40) return 16'($urandom_range(0, 127) * 512);
    if (dice < 70) return 16'($urandom);
    if (dice < 85) return 16'(65536 - $urandom_range(1, 4) * 512);
    return 16'(65535 - $urandom_range(0, 600));
  endfunction

  // mostly a small pool (hits, slot conflicts), some near the window edge
  function automatic logic [SECTOR_ADDR_W-1:0] pick_start(int unsigned len);
    logic [SECTOR_ADDR_W:0] start;
    int unsigned            dice;
    int unsigned            back;
    dice = $urandom_range(0, 99);
    if (dice < 35) begin
      start = $urandom_range(0, 8191);
    end else if (dice < 55 && recent_starts.size() != 0) begin
      start = recent_starts[$urandom_range(0, recent_starts.size() - 1)];
    end else if (dice < 75) begin
      back = $urandom_range(0, 2 * len + 4);
      start = (cache_model.window > back) ? cache_model.window - back : '0;
    end else if (dice < 92) begin
      start = {1'b0, 16'($urandom), 32'($urandom)};
    end else begin
      start = ADDR_SPAN - len;
    end
    if (start + len > ADDR_SPAN) start = ADDR_SPAN - len;
    return start[SECTOR_ADDR_W-1:0];
  endfunction

  task automatic send_word(sector_word_t w);
    int gap;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    req_ch.valid            = 1'b1;
    req_ch.opcode           = w.opcode;
    req_ch.sector_addr      = w.sector_addr;
    req_ch.request_end      = w.request_end;
    req_ch.first_of_request = w.first_of_request;
    req_ch.buffer_offset    = w.buffer_offset;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_request(logic [SECTOR_ADDR_W-1:0] start, int unsigned len, bit broken);
    sector_word_t         w;
    logic [BUF_OFF_W-1:0] boff;
    boff = pick_offset();
    for (int i = 0; i < len; i++) begin
      w = make_word(OP_READ, start + i, {1'b0, start} + len, i == 0, boff + 16'(i * 512));
      // broken request: stray or missing first mark, bogus end
      if (broken && $urandom_range(0, 3) == 0) begin
        w.first_of_request = ~w.first_of_request;
        w.request_end = random_end();
      end
      send_word(w);
    end
    recent_starts.push_back(start);
    if (recent_starts.size() > 16) void'(recent_starts.pop_front());
  endtask

  task automatic send_fills(logic [SECTOR_ADDR_W-1:0] start, int unsigned len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) != 0)
        send_word(make_word(OP_FILL, start + i, random_end(), 1'($urandom), 16'($urandom)));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (cache_model.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(scc_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    cache_model.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(logic [1:0] mode_sel, logic [RAM_SECTOR_W-1:0] window_sectors,
                           logic [RUN_W-1:0] run_cap);
    drain_results();
    repeat (4) @(posedge clk);
    write_cfg(CFG_MODE, {21'($urandom), mode_sel});
    write_cfg(CFG_WINDOW, window_sectors);
    write_cfg(CFG_MAX_RUN, {16'($urandom), run_cap});
  endtask

  task automatic run_random(int unsigned n);
    int unsigned              first_item;
    int unsigned              dice;
    int unsigned              len;
    logic [SECTOR_ADDR_W-1:0] start;
    first_item = items_sent;
    while (items_sent - first_item < n) begin
      dice = $urandom_range(0, 99);
      if (dice < 60) begin
        dice = $urandom_range(0, 9);
        len = (dice < 7) ? $urandom_range(1, 12) :
              (dice < 9) ? $urandom_range(13, 70) : $urandom_range(71, 140);
        start = pick_start(len);
        send_request(start, len, $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) < 7) send_fills(start, len);
      end else if (dice < 72) begin
        len = $urandom_range(1, 4);
        start = pick_start(len);
        for (int i = 0; i < len; i++)
          send_word(make_word(OP_WRITE_OK, start + i, random_end(), 1'($urandom),
                              16'($urandom)));
      end else if (dice < 84) begin
        send_word(make_word(OP_WRITE_ERR, pick_start(1), random_end(), 1'($urandom),
                            16'($urandom)));
      end else if (dice < 90) begin
        send_word(make_word(OP_FILL, pick_start(1), random_end(), 1'($urandom),
                            16'($urandom)));
      end else begin
        send_word(make_word(scc_op_t'($urandom_range(0, 3)), {16'($urandom), 32'($urandom)},
                            random_end(), 1'($urandom), 16'($urandom)));
      end
    end
  endtask

  initial begin
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_MODE;
    cfg_data                = '0;
    req_ch.valid            = 1'b0;
    req_ch.opcode           = OP_READ;
    req_ch.sector_addr      = '0;
    req_ch.request_end      = '0;
    req_ch.first_of_request = 1'b0;
    req_ch.buffer_offset    = '0;
    rsp_ch.ready            = 1'b0;
    src_gaps                = 1'b1;
    sink_stalls             = 1'b1;
    items_sent              = 0;
    idle_cycles             = 0;
    stall_left              = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // pass-through at reset settings
    send_word(make_word(OP_READ, 48'd1000, 49'd1002, 1'b1, 16'h0000));
    send_word(make_word(OP_READ, 48'd1001, 49'd1002, 1'b0, 16'h0200));
    send_word(make_word(OP_WRITE_OK, 48'd5, 49'd6, 1'b0, 16'h0000));
    send_word(make_word(OP_WRITE_ERR, 48'd5, 49'd6, 1'b0, 16'h0000));
    send_word(make_word(OP_FILL, 48'd5, 49'd6, 1'b0, 16'h0000));

    // demand cache: miss, fill, hit, invalidate, slot conflict, top address
    configure(MODE_CACHE, '0, 7'd64);
    send_word(make_word(OP_READ, 48'd7, 49'd8, 1'b1, 16'h1000));
    send_word(make_word(OP_FILL, 48'd7, 49'd8, 1'b0, 16'h0000));
    send_word(make_word(OP_READ, 48'd7, 49'd8, 1'b1, 16'h1000));
    send_word(make_word(OP_WRITE_ERR, 48'd7, 49'd8, 1'b0, 16'h0000));
    send_word(make_word(OP_READ, 48'd7, 49'd8, 1'b1, 16'h1000));
    send_word(make_word(OP_WRITE_ERR, 48'd7, 49'd8, 1'b0, 16'h0000));
    send_word(make_word(OP_WRITE_OK, 48'd4103, 49'd4104, 1'b0, 16'h0000));
    send_word(make_word(OP_READ, 48'd7, 49'd8, 1'b1, 16'h0000));
    send_word(make_word(OP_READ, 48'hFFFF_FFFF_FFFF, ADDR_SPAN, 1'b1, 16'hFFFF));
    send_word(make_word(OP_FILL, 48'hFFFF_FFFF_FFFF, ADDR_SPAN, 1'b0, 16'hFFFF));

    // window: whole request inside, partial request, malformed end, writes
    configure(MODE_WINDOW, 23'd100, 7'd64);
    send_word(make_word(OP_READ, 48'd98, 49'd100, 1'b1, 16'h0000));
    send_word(make_word(OP_READ, 48'd99, 49'd100, 1'b0, 16'h0200));
    send_word(make_word(OP_READ, 48'd99, 49'd101, 1'b1, 16'h0000));
    send_word(make_word(OP_READ, 48'd50, 49'd40, 1'b0, 16'h0200));
    send_word(make_word(OP_WRITE_OK, 48'd99, 49'd100, 1'b0, 16'h0000));
    send_word(make_word(OP_WRITE_OK, 48'd100, 49'd101, 1'b0, 16'h0000));
    send_word(make_word(OP_FILL, 48'd3, 49'd4, 1'b0, 16'h0000));

    configure(MODE_CACHE, '0, 7'd64);
    run_random(300);
    // a cap of zero behaves as one
    configure(MODE_CACHE, 23'd4096, 7'd0);
    run_random(100);
    configure(MODE_WINDOW, 23'd5242880, 7'd8);
    run_random(200);
    src_gaps = 1'b0;
    configure(MODE_WINDOW, '0, 7'd127);
    run_random(100);
    src_gaps = 1'b1;
    configure(MODE_WINDOW, 23'($urandom_range(1, 5242880)), 7'($urandom_range(1, 64)));
    run_random(150);
    sink_stalls = 1'b0;
    configure(MODE_PASS, 23'($urandom), 7'd1);
    run_random(100);
    sink_stalls = 1'b1;
    // unused mode code acts as pass-through
    configure(2'd3, 23'd2000, 7'd100);
    run_random(50);
    configure(MODE_CACHE, 23'($urandom), 7'($urandom_range(1, 64)));
    run_random(125);
    drain_results();
    run_random(125);
    drain_results();
    write_cfg(CFG_NONE, 23'($urandom));
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    configure(MODE_CACHE, '0, 7'd64);
    run_random(200);

    drain_results();
    repeat (10) @(posedge clk);
    if (cache_model.mismatches == 0 && cache_model.pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
